// ===== rtl/core/sdas_pkg.sv =====
// Shared widths and defaults for the signed decimal adder/subtractor.
`default_nettype none

package sdas_pkg;

   localparam int SDAS_DATA_W      = 64;
   localparam int SDAS_MAX_DIGITS  = SDAS_DATA_W / 4;
   localparam int SDAS_DIGITS_DEF  = 16;
   localparam logic [3:0] SDAS_DIGIT_MAX = 4'd9;

   typedef logic [SDAS_DATA_W-1:0] sdas_word_type;

endpackage : sdas_pkg

`default_nettype wire

// ===== rtl/core/signed_decimal_add_sub.sv =====
// Signed decimal adder/subtractor on sign-magnitude packed BCD operands.
//
//   channel | ports | direction | payload
//   --------+-------+-----------+-----------------------------------------------------
//   request | req_  | in        | cmd, a_negative, a_digits, b_negative, b_digits
//   result  | rsp_  | out       | result_negative, result_digits, carry_lost
//
// Each request is held first in the input register and then in the result register;
// rsp_valid rises when it enters the result register, and it leaves once rsp_ready is
// high. One request is accepted per cycle unless a stall holds the full input register;
// the three decimal adders work in parallel between the two registers. A stalled
// result holds the pipeline, and a new request is still taken while the input register
// is free.
// Reset is synchronous and clears only the valid flags.
`default_nettype none

module signed_decimal_add_sub #(
   parameter int DIGITS = sdas_pkg::SDAS_DIGITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_cmd,
   input  wire logic                  req_a_negative,
   input  wire sdas_pkg::sdas_word_type req_a_digits,
   input  wire logic                  req_b_negative,
   input  wire sdas_pkg::sdas_word_type req_b_digits,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_result_negative,
   output      sdas_pkg::sdas_word_type rsp_result_digits,
   output      logic                  rsp_carry_lost
);
   import sdas_pkg::*;

   localparam int W = 4 * DIGITS;
   localparam logic [W-1:0] SIXES = {DIGITS{4'h6}};
   localparam logic [W-1:0] NINES = {DIGITS{4'h9}};

   typedef struct packed {
      logic         sum_carry;
      logic [W-1:0] digits;
   } dec_sum_type;

   // Clamp each nibble above nine down to nine.
   function automatic logic [W-1:0] clamp_digits(input logic [W-1:0] v);
      logic [W-1:0] r;
      r = v;
      for (int i = 0; i < DIGITS; i++) begin
         if (v[4*i +: 4] > SDAS_DIGIT_MAX) begin
            r[4*i +: 4] = SDAS_DIGIT_MAX;
         end
      end
      return r;
   endfunction

   // Decimal add through one binary add with a bias of six in every digit.
   function automatic dec_sum_type dec_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic cin);
      logic [W:0]   s;
      logic [W:0]   cv;
      dec_sum_type  r;
      s  = {1'b0, x} + {1'b0, y} + {1'b0, SIXES} + {{W{1'b0}}, cin};
      cv = s ^ {1'b0, x} ^ {1'b0, y} ^ {1'b0, SIXES};
      r.sum_carry = s[W];
      for (int i = 0; i < DIGITS; i++) begin
         if (cv[4*i+4]) begin
            r.digits[4*i +: 4] = s[4*i +: 4];
         end else begin
            r.digits[4*i +: 4] = s[4*i +: 4] - 4'h6;
         end
      end
      return r;
   endfunction

   logic         in_valid_ff;
   logic         cmd_ff;
   logic         a_neg_ff;
   logic [W-1:0] a_ff;
   logic         b_neg_ff;
   logic [W-1:0] b_ff;

   logic         out_valid_ff;
   logic         out_neg_ff;
   logic [W-1:0] out_digits_ff;
   logic         out_carry_ff;

   logic         advance;
   logic         out_neg_in;
   logic [W-1:0] out_digits_in;
   logic         out_carry_in;

   logic [W-1:0] a_mag;
   logic [W-1:0] b_mag;
   logic         eb_neg;
   dec_sum_type  sum_ab;
   dec_sum_type  diff_ab;
   dec_sum_type  diff_ba;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= req_cmd;
         a_neg_ff <= req_a_negative;
         a_ff     <= req_a_digits[W-1:0];
         b_neg_ff <= req_b_negative;
         b_ff     <= req_b_digits[W-1:0];
      end
   end

   always_comb begin
      a_mag   = clamp_digits(a_ff);
      b_mag   = clamp_digits(b_ff);
      eb_neg  = b_neg_ff ^ cmd_ff;
      sum_ab  = dec_add(a_mag, b_mag, 1'b0);
      diff_ab = dec_add(a_mag, NINES - b_mag, 1'b1);
      diff_ba = dec_add(b_mag, NINES - a_mag, 1'b1);

      out_carry_in  = 1'b0;
      out_digits_in = sum_ab.digits;
      out_neg_in    = a_neg_ff;
      if (a_neg_ff == eb_neg) begin
         out_carry_in = sum_ab.sum_carry;
      end else if (!diff_ab.sum_carry) begin
         out_digits_in = diff_ba.digits;
         out_neg_in    = eb_neg;
      end else begin
         out_digits_in = diff_ab.digits;
         if (diff_ab.digits == '0) begin
            out_neg_in = cmd_ff & a_neg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_neg_ff    <= out_neg_in;
         out_digits_ff <= out_digits_in;
         out_carry_ff  <= out_carry_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_negative = out_neg_ff;
   assign rsp_result_digits   = SDAS_DATA_W'(out_digits_ff);
   assign rsp_carry_lost      = out_carry_ff;

endmodule : signed_decimal_add_sub

`default_nettype wire

// ===== rtl/core/sdas_checker.sv =====
// Port-level assertions for the signed decimal adder/subtractor, bound to the top level.
`default_nettype none

module sdas_checker #(
   parameter int DIGITS = sdas_pkg::SDAS_DIGITS_DEF
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_result_negative,
   input wire sdas_pkg::sdas_word_type rsp_result_digits,
   input wire logic                    rsp_carry_lost
);
   import sdas_pkg::*;

   localparam sdas_word_type HIGH_MASK = {SDAS_DATA_W{1'b1}} << (4 * DIGITS);

   function automatic logic all_bcd(input sdas_word_type v);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < SDAS_MAX_DIGITS; i++) begin
         if (v[4*i +: 4] > SDAS_DIGIT_MAX) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_digits)
         && $stable(rsp_result_negative) && $stable(rsp_carry_lost))
      else $error("stalled result changed");

   a_digits_bcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> all_bcd(rsp_result_digits))
      else $error("result digit above nine");

   a_high_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_digits & HIGH_MASK) == '0)
      else $error("result digit beyond the configured count");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled while the result side is free");

endmodule : sdas_checker

bind signed_decimal_add_sub sdas_checker #(.DIGITS(DIGITS)) u_sdas_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_result_negative (rsp_result_negative),
   .rsp_result_digits   (rsp_result_digits),
   .rsp_carry_lost      (rsp_carry_lost)
);

`default_nettype wire

// ===== verif/signed_decimal_add_sub_tb.sv =====
// Self-checking testbench for the signed decimal adder/subtractor.
`timescale 1ns / 1ps

module signed_decimal_add_sub_tb;

   import sdas_pkg::*;

   localparam int DIGITS       = SDAS_DIGITS_DEF;
   localparam int RADIX        = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 235;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUB = 1'b1;

   typedef struct packed {
      logic          cmd;
      logic          a_neg;
      sdas_word_type a;
      logic          b_neg;
      sdas_word_type b;
   } operands_type;

   typedef struct packed {
      logic          neg;
      sdas_word_type digits;
      logic          carry;
   } signed_sum_type;

   class sum_checker_type;
      signed_sum_type expected_sums[$];
      int             mismatches;
      int             results_seen;
      int             carries_seen;
      int             differences_seen;

      function logic [3:0] digit_of(sdas_word_type v, int i);
         logic [3:0] d;
         d = v[4*i +: 4];
         return (d > SDAS_DIGIT_MAX) ? SDAS_DIGIT_MAX : d;
      endfunction

      function int compare_mags(sdas_word_type x, sdas_word_type y);
         for (int i = DIGITS - 1; i >= 0; i--) begin
            if (digit_of(x, i) > digit_of(y, i)) return 1;
            if (digit_of(x, i) < digit_of(y, i)) return -1;
         end
         return 0;
      endfunction

      function sdas_word_type add_mags(sdas_word_type x, sdas_word_type y,
                                       output logic carry);
         sdas_word_type r;
         int            c;
         int            s;
         r = '0;
         c = 0;
         for (int i = 0; i < DIGITS; i++) begin
            s = digit_of(x, i) + digit_of(y, i) + c;
            c = (s >= RADIX) ? 1 : 0;
            r[4*i +: 4] = 4'(s - c * RADIX);
         end
         carry = (c != 0);
         return r;
      endfunction

      function sdas_word_type sub_mags(sdas_word_type x, sdas_word_type y);
         sdas_word_type r;
         int            brw;
         int            dx;
         int            dy;
         r = '0;
         brw = 0;
         for (int i = 0; i < DIGITS; i++) begin
            dx = digit_of(x, i);
            dy = digit_of(y, i) + brw;
            brw = (dx < dy) ? 1 : 0;
            r[4*i +: 4] = 4'(dx + brw * RADIX - dy);
         end
         return r;
      endfunction

      function signed_sum_type predict_sum(operands_type op);
         signed_sum_type res;
         logic           eff_b_neg;
         int             cmp;
         res = '0;
         eff_b_neg = op.b_neg ^ op.cmd;
         if (op.a_neg == eff_b_neg) begin
            res.digits = add_mags(op.a, op.b, res.carry);
            res.neg = op.a_neg;
         end else begin
            cmp = compare_mags(op.a, op.b);
            if (cmp > 0) begin
               res.digits = sub_mags(op.a, op.b);
               res.neg = op.a_neg;
            end else if (cmp < 0) begin
               res.digits = sub_mags(op.b, op.a);
               res.neg = eff_b_neg;
            end else begin
               res.digits = '0;
               res.neg = (op.cmd == CMD_SUB) ? op.a_neg : 1'b0;
            end
         end
         return res;
      endfunction

      function void note_request(operands_type op);
         signed_sum_type res;
         res = predict_sum(op);
         if (res.carry) carries_seen++;
         if (op.a_neg != (op.b_neg ^ op.cmd)) differences_seen++;
         expected_sums.push_back(res);
      endfunction

      function void check_result(logic neg, sdas_word_type digits, logic carry);
         signed_sum_type exp_sum;
         results_seen++;
         if (expected_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: result with no request pending: neg=%b digits=%h carry=%b",
                        neg, digits, carry);
            return;
         end
         exp_sum = expected_sums.pop_front();
         if (neg !== exp_sum.neg || digits !== exp_sum.digits || carry !== exp_sum.carry) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: expected neg=%b digits=%h carry=%b, got neg=%b digits=%h carry=%b",
                        exp_sum.neg, exp_sum.digits, exp_sum.carry, neg, digits, carry);
         end
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          req_cmd;
   logic          req_a_negative;
   sdas_word_type req_a_digits;
   logic          req_b_negative;
   sdas_word_type req_b_digits;
   logic          rsp_valid;
   logic          rsp_ready;
   logic          rsp_result_negative;
   sdas_word_type rsp_result_digits;
   logic          rsp_carry_lost;

   int              req_idle_pct;
   int              rsp_idle_pct;
   int              cycle_count;
   sum_checker_type sum_board = new();

   signed_decimal_add_sub #(.DIGITS(DIGITS)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_a_negative      (req_a_negative),
      .req_a_digits        (req_a_digits),
      .req_b_negative      (req_b_negative),
      .req_b_digits        (req_b_digits),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_negative (rsp_result_negative),
      .rsp_result_digits   (rsp_result_digits),
      .rsp_carry_lost      (rsp_carry_lost)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sum_board.check_result(rsp_result_negative, rsp_result_digits, rsp_carry_lost);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sum_board.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic operands_type make_ops(logic cmd, logic a_neg, sdas_word_type a,
                                             logic b_neg, sdas_word_type b);
      operands_type op;
      op.cmd = cmd;
      op.a_neg = a_neg;
      op.a = a;
      op.b_neg = b_neg;
      op.b = b;
      return op;
   endfunction

   function automatic sdas_word_type rand_bcd(int ndigits);
      sdas_word_type r;
      r = '0;
      for (int i = 0; i < ndigits; i++) r[4*i +: 4] = 4'($urandom_range(9));
      return r;
   endfunction

   function automatic operands_type random_ops();
      operands_type op;
      int           mode;
      int           pos;
      mode = $urandom_range(9);
      op.cmd = 1'($urandom_range(1));
      op.a_neg = 1'($urandom_range(1));
      op.b_neg = 1'($urandom_range(1));
      op.a = rand_bcd($urandom_range(1, DIGITS));
      op.b = rand_bcd($urandom_range(1, DIGITS));
      case (mode)
         4: begin
            op.a = {$urandom, $urandom};
            op.b = {$urandom, $urandom};
         end
         5: op.b = op.a;
         6: begin
            for (int i = 0; i < DIGITS; i++) begin
               op.a[4*i +: 4] = 4'($urandom_range(8, 9));
               op.b[4*i +: 4] = 4'($urandom_range(0, 9));
            end
         end
         7: begin
            op.a = rand_bcd($urandom_range(1, 3));
            op.b = rand_bcd($urandom_range(1, 3));
         end
         8: begin
            op.b = op.a;
            pos = $urandom_range(DIGITS - 1);
            op.b[4*pos +: 4] = 4'($urandom_range(9));
         end
         9: op.b = {$urandom, $urandom};
         default: ;
      endcase
      return op;
   endfunction

   task automatic send_request(input operands_type op);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid      <= 1'b1;
      req_cmd        <= op.cmd;
      req_a_negative <= op.a_neg;
      req_a_digits   <= op.a;
      req_b_negative <= op.b_neg;
      req_b_digits   <= op.b;
      do @(posedge clock); while (!req_ready);
      sum_board.note_request(op);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sum_board.pending() != 0);
   endtask

   task automatic run_phase(int snd_pct, int rcv_pct, int count);
      req_idle_pct = snd_pct;
      rsp_idle_pct = rcv_pct;
      for (int n = 0; n < count; n++) begin
         send_request(random_ops());
         if (n == count / 2) wait_for_drain();
      end
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_a_negative = 1'b0;
      req_a_digits = '0;
      req_b_negative = 1'b0;
      req_b_digits = '0;
      rsp_ready = 1'b0;
      req_idle_pct = 0;
      rsp_idle_pct = 50;
      cycle_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(make_ops(CMD_ADD, 1'b0, 64'h0, 1'b0, 64'h0));
      send_request(make_ops(CMD_ADD, 1'b1, 64'h0, 1'b1, 64'h0));
      send_request(make_ops(CMD_SUB, 1'b1, 64'h0, 1'b0, 64'h0));
      send_request(make_ops(CMD_SUB, 1'b0, 64'h0, 1'b1, 64'h0));
      send_request(make_ops(CMD_ADD, 1'b0, 64'h9999_9999_9999_9999, 1'b0, 64'h1));
      send_request(make_ops(CMD_ADD, 1'b1, 64'h9999_9999_9999_9999,
                            1'b1, 64'h9999_9999_9999_9999));
      send_request(make_ops(CMD_ADD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0));
      send_request(make_ops(CMD_ADD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                            1'b0, 64'hAAAA_AAAA_AAAA_AAAA));
      send_request(make_ops(CMD_ADD, 1'b0, 64'h5, 1'b1, 64'h5));
      send_request(make_ops(CMD_ADD, 1'b1, 64'h5, 1'b0, 64'h5));
      send_request(make_ops(CMD_SUB, 1'b0, 64'h7, 1'b0, 64'h7));
      send_request(make_ops(CMD_SUB, 1'b1, 64'h7, 1'b1, 64'h7));
      send_request(make_ops(CMD_SUB, 1'b0, 64'hA, 1'b0, 64'h9));
      send_request(make_ops(CMD_SUB, 1'b0, 64'h500, 1'b0, 64'h3));
      send_request(make_ops(CMD_SUB, 1'b1, 64'h500, 1'b1, 64'h3));
      send_request(make_ops(CMD_SUB, 1'b0, 64'h3, 1'b0, 64'h500));
      send_request(make_ops(CMD_ADD, 1'b0, 64'h500, 1'b1, 64'h3));
      send_request(make_ops(CMD_ADD, 1'b0, 64'h3, 1'b1, 64'h500));
      send_request(make_ops(CMD_SUB, 1'b0, 64'h1000_0000_0000_0000, 1'b0, 64'h1));
      send_request(make_ops(CMD_SUB, 1'b1, 64'h1, 1'b0, 64'h9999_9999_9999_9999));
      send_request(make_ops(CMD_SUB, 1'b1, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      wait_for_drain();

      run_phase(35, 75, PHASE_ITEMS);
      run_phase(75, 35, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results: %0d with a lost carry, %0d by magnitude difference,",
               sum_board.results_seen, sum_board.carries_seen, sum_board.differences_seen);
      $display("under three sender and receiver idle mixes; %0d mismatches.",
               sum_board.mismatches);
      if (sum_board.mismatches == 0 && sum_board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
